// ===== sv/rdc_pkg.sv =====
package rdc_pkg;

    // width of every payload field on the channels
    localparam int unsigned DATA_W = 32;

endpackage

// ===== sv/rdc_in_if.sv =====
interface rdc_in_if;

    logic                         valid;
    logic                         ready;
    logic [rdc_pkg::DATA_W-1:0]   dividend;
    logic [rdc_pkg::DATA_W-1:0]   divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);

endinterface

// ===== sv/rdc_out_if.sv =====
interface rdc_out_if;

    logic                         valid;
    logic                         ready;
    logic [rdc_pkg::DATA_W-1:0]   quotient;
    logic [rdc_pkg::DATA_W-1:0]   remainder;

    modport source (output valid, output quotient, output remainder, input ready);
    modport sink   (input valid, input quotient, input remainder, output ready);

endinterface

// ===== sv/restoring_divider_core.sv =====
// channel   dir   modport   payload                          transaction
// i_in      in    sink      dividend[31:0], divisor[31:0]    valid && ready
// o_out     out   source    quotient[31:0], remainder[31:0]  valid && ready
//
// one operand pair can enter every cycle unless the output stalls the chain
// each pipeline stage does one shift, subtract and compare, so WIDTH stages
// reset (synchronous, active low) clears only the stage valid bits
// a full stage holds while the one after it is full and cannot move
// empty stages let later items close up, so bubbles never block the input
module restoring_divider_core #(
    parameter int unsigned WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rdc_in_if.sink     i_in,
    rdc_out_if.source  o_out
);

    localparam int unsigned DW = rdc_pkg::DATA_W;

    // per-stage state: partial remainder, dividend bits still to come with
    // quotient bits shifted in at the bottom, and the divisor
    logic             r_vld [WIDTH];
    logic [WIDTH-1:0] r_rem [WIDTH];
    logic [WIDTH-1:0] r_qd  [WIDTH];
    logic [WIDTH-1:0] r_den [WIDTH];

    logic [WIDTH-1:0] n_rem [WIDTH];
    logic [WIDTH-1:0] n_qd  [WIDTH];

    // source side of each stage
    logic             w_src_vld [WIDTH];
    logic [WIDTH-1:0] w_src_rem [WIDTH];
    logic [WIDTH-1:0] w_src_qd  [WIDTH];
    logic [WIDTH-1:0] w_src_den [WIDTH];

    // stage k may load when it is empty or stage k+1 can load
    logic [WIDTH:0]   w_rdy;

    // operand fit: extra input bits drop, missing ones are zero
    logic [WIDTH+DW-1:0] w_num_ext;
    logic [WIDTH+DW-1:0] w_den_ext;
    logic [DW+WIDTH-1:0] w_quo_ext;
    logic [DW+WIDTH-1:0] w_rem_ext;

    assign w_num_ext = {{WIDTH{1'b0}}, i_in.dividend};
    assign w_den_ext = {{WIDTH{1'b0}}, i_in.divisor};

    // ready chain from the output back to the input
    always_comb begin
        w_rdy[WIDTH] = o_out.ready;
        for (int k = WIDTH - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign i_in.ready = w_rdy[0];

    // stage inputs: the first stage takes the operands with a zero remainder
    always_comb begin
        w_src_vld[0] = i_in.valid;
        w_src_rem[0] = '0;
        w_src_qd[0]  = w_num_ext[WIDTH-1:0];
        w_src_den[0] = w_den_ext[WIDTH-1:0];
        for (int k = 1; k < WIDTH; k++) begin
            w_src_vld[k] = r_vld[k-1];
            w_src_rem[k] = r_rem[k-1];
            w_src_qd[k]  = r_qd[k-1];
            w_src_den[k] = r_den[k-1];
        end
    end

    // one restoring step per stage; the extra top bit keeps the compare exact
    always_comb begin
        logic [WIDTH:0] v_shift;
        logic [WIDTH:0] v_diff;
        v_shift = '0;
        v_diff  = '0;
        for (int k = 0; k < WIDTH; k++) begin
            v_shift = {w_src_rem[k], w_src_qd[k][WIDTH-1]};
            v_diff  = v_shift - {1'b0, w_src_den[k]};
            // no borrow means shifted remainder >= divisor: keep the difference
            if (!v_diff[WIDTH]) begin
                n_rem[k] = v_diff[WIDTH-1:0];
            end else begin
                n_rem[k] = v_shift[WIDTH-1:0];
            end
            n_qd[k] = {w_src_qd[k][WIDTH-2:0], !v_diff[WIDTH]};
        end
    end

    // valid bits: cleared by reset, follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIDTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < WIDTH; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_src_vld[k];
                end
            end
        end
    end

    // payload: loads only with a valid item, so a stall holds it
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < WIDTH; k++) begin
            if (w_rdy[k] && w_src_vld[k]) begin
                r_rem[k] <= n_rem[k];
                r_qd[k]  <= n_qd[k];
                r_den[k] <= w_src_den[k];
            end
        end
    end

    // last stage is the output register
    assign w_quo_ext = {{DW{1'b0}}, r_qd[WIDTH-1]};
    assign w_rem_ext = {{DW{1'b0}}, r_rem[WIDTH-1]};

    assign o_out.valid     = r_vld[WIDTH-1];
    assign o_out.quotient  = w_quo_ext[DW-1:0];
    assign o_out.remainder = w_rem_ext[DW-1:0];

`ifndef SYNTHESIS
    // a finished result with a nonzero divisor leaves a remainder below it
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[WIDTH-1] && (r_den[WIDTH-1] != '0)) |-> (r_rem[WIDTH-1] < r_den[WIDTH-1]))
        else $error("remainder not below divisor");

    // division by zero gives an all-ones quotient
    a_div_zero_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[WIDTH-1] && (r_den[WIDTH-1] == '0)) |-> (r_qd[WIDTH-1] == '1))
        else $error("divide by zero quotient not all ones");

    // an accepted transaction lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted item missing from first stage");

    // a blocked first stage keeps its item intact
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !w_rdy[1]) |=> (r_vld[0] && $stable(r_rem[0]) && $stable(r_qd[0])
            && $stable(r_den[0])))
        else $error("stalled stage changed");
`endif

endmodule
